// ===== design/dq_pkg.sv =====
`default_nettype none

package dq_pkg;

  localparam int DEPTH      = 16;
  localparam int VALUE_BITS = 32;
  localparam int IDX_W      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W      = $clog2(DEPTH + 1);

  typedef enum logic [2:0] {
    OP_PUSH_FRONT = 3'd0,
    OP_PUSH_BACK  = 3'd1,
    OP_POP_FRONT  = 3'd2,
    OP_POP_BACK   = 3'd3,
    OP_PURGE      = 3'd4
  } dq_op_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_PURGE_RD,
    ST_PURGE_WR,
    ST_RD_FRONT,
    ST_RD_BACK,
    ST_FINISH
  } dq_state_e;

  typedef struct packed {
    logic                  we;
    logic [IDX_W-1:0]      waddr;
    logic [VALUE_BITS-1:0] wdata;
    logic [IDX_W-1:0]      raddr;
  } dq_ram_req_t;

  // Circular index: base + off, folded back into 0..DEPTH-1.
  function automatic logic [IDX_W-1:0] wrap_add(input logic [IDX_W-1:0] base,
                                                input logic [CNT_W-1:0] off);
    logic [CNT_W:0] sum;
    sum = {{(CNT_W + 1 - IDX_W){1'b0}}, base} + {1'b0, off};
    if (sum >= (CNT_W + 1)'(DEPTH)) begin
      sum = sum - (CNT_W + 1)'(DEPTH);
    end
    return sum[IDX_W-1:0];
  endfunction

endpackage

`default_nettype wire

// ===== design/dq_ram.sv =====
`default_nettype none

module dq_ram
  import dq_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire dq_ram_req_t           req_i,
  output logic [VALUE_BITS-1:0]      rdata_o
);

  logic [VALUE_BITS-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem_q[req_i.waddr] <= req_i.wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_o <= mem_q[req_i.raddr];
  end

endmodule

`default_nettype wire

// ===== design/deque_with_negative_purge.sv =====
// Sequence: an accepted push or pop runs an execute step, a front read, a back read
//   when the deque is left non-empty, and a finish step that raises the result strobe;
//   purge adds a read step and a write step per stored entry plus a closing check.
// Throughput: one transaction at a time; busy stays high until the strobe, and
//   the next start is taken the cycle after it. The single memory read port sets this.
// Reset (rst_ni low, asynchronous): head and count clear, the sequencer idles;
//   store contents stay undefined. The receiver cannot stall results.
`default_nettype none

module deque_with_negative_purge
  import dq_pkg::*;
(
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         start,
  output logic                              busy,
  input  wire logic [2:0]                   opcode_i,
  input  wire logic signed [VALUE_BITS-1:0] value_i,
  output logic                              result_valid_o,
  output logic                              ok_o,
  output logic [CNT_W-1:0]                  entry_count_o,
  output logic                              is_empty_o,
  output logic signed [VALUE_BITS-1:0]      front_value_o,
  output logic signed [VALUE_BITS-1:0]      back_value_o
);

  // Control state.
  dq_state_e        state_q, state_d;
  logic [IDX_W-1:0] head_q, head_d;
  logic [CNT_W-1:0] count_q, count_d;

  // Per-transaction payload and walk counters.
  logic [2:0]            op_q;
  logic [VALUE_BITS-1:0] value_q;
  logic                  ok_q, ok_d;
  logic [VALUE_BITS-1:0] front_q, front_d;
  logic [CNT_W-1:0]      idx_q, idx_d;
  logic [CNT_W-1:0]      kept_q, kept_d;

  dq_ram_req_t           ram_req;
  logic [VALUE_BITS-1:0] ram_rdata;

  logic accept;

  assign accept = start && !busy;
  assign busy   = (state_q != ST_IDLE);

  dq_ram u_ram (
    .clk_i   (clk_i),
    .req_i   (ram_req),
    .rdata_o (ram_rdata)
  );

  // Sequencer: one memory access per cycle drives every step.
  always_comb begin
    state_d       = state_q;
    head_d        = head_q;
    count_d       = count_q;
    ok_d          = ok_q;
    front_d       = front_q;
    idx_d         = idx_q;
    kept_d        = kept_q;
    ram_req.we    = 1'b0;
    ram_req.waddr = head_q;
    ram_req.wdata = value_q;
    ram_req.raddr = head_q;

    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          state_d = ST_EXEC;
        end
      end

      ST_EXEC: begin
        idx_d   = '0;
        kept_d  = '0;
        ok_d    = 1'b0;
        state_d = ST_RD_FRONT;
        case (op_q)
          OP_PUSH_FRONT: begin
            if (count_q < CNT_W'(DEPTH)) begin
              // Step the head back one slot and store there.
              head_d        = (head_q == '0) ? IDX_W'(DEPTH - 1) : head_q - 1'b1;
              ram_req.we    = 1'b1;
              ram_req.waddr = head_d;
              count_d       = count_q + 1'b1;
              ok_d          = 1'b1;
            end
          end
          OP_PUSH_BACK: begin
            if (count_q < CNT_W'(DEPTH)) begin
              ram_req.we    = 1'b1;
              ram_req.waddr = wrap_add(head_q, count_q);
              count_d       = count_q + 1'b1;
              ok_d          = 1'b1;
            end
          end
          OP_POP_FRONT: begin
            if (count_q != '0) begin
              head_d  = wrap_add(head_q, CNT_W'(1));
              count_d = count_q - 1'b1;
              ok_d    = 1'b1;
            end
          end
          OP_POP_BACK: begin
            if (count_q != '0) begin
              count_d = count_q - 1'b1;
              ok_d    = 1'b1;
            end
          end
          OP_PURGE: begin
            ok_d    = 1'b1;
            state_d = ST_PURGE_RD;
          end
          default: begin
            // Undefined opcode: report failure, touch nothing.
            ok_d = 1'b0;
          end
        endcase
      end

      ST_PURGE_RD: begin
        // Walk done: survivors are packed from the head on.
        if (idx_q == count_q) begin
          count_d = kept_q;
          state_d = ST_RD_FRONT;
        end else begin
          ram_req.raddr = wrap_add(head_q, idx_q);
          state_d       = ST_PURGE_WR;
        end
      end

      ST_PURGE_WR: begin
        // Keep non-negative entries; write slot never passes the read slot.
        if (!ram_rdata[VALUE_BITS-1]) begin
          ram_req.we    = 1'b1;
          ram_req.waddr = wrap_add(head_q, kept_q);
          ram_req.wdata = ram_rdata;
          kept_d        = kept_q + 1'b1;
        end
        idx_d   = idx_q + 1'b1;
        state_d = ST_PURGE_RD;
      end

      ST_RD_FRONT: begin
        ram_req.raddr = head_q;
        state_d       = (count_q == '0) ? ST_FINISH : ST_RD_BACK;
      end

      ST_RD_BACK: begin
        front_d       = ram_rdata;
        ram_req.raddr = wrap_add(head_q, count_q - 1'b1);
        state_d       = ST_FINISH;
      end

      ST_FINISH: begin
        state_d = ST_IDLE;
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      head_q  <= '0;
      count_q <= '0;
    end else begin
      state_q <= state_d;
      head_q  <= head_d;
      count_q <= count_d;
    end
  end

  // Payload registers: no reset needed.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q    <= opcode_i;
      value_q <= value_i;
    end
    ok_q    <= ok_d;
    front_q <= front_d;
    idx_q   <= idx_d;
    kept_q  <= kept_d;
  end

  // Result: one cycle strobe in the finish step; back value is the last read.
  assign result_valid_o = (state_q == ST_FINISH);
  assign ok_o           = ok_q;
  assign entry_count_o  = count_q;
  assign is_empty_o     = (count_q == '0);
  assign front_value_o  = is_empty_o ? '0 : front_q;
  assign back_value_o   = is_empty_o ? '0 : ram_rdata;

  // Assertions.
  a_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(DEPTH))
    else $error("stored count exceeds depth");

  a_accept_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> busy && !result_valid_o)
    else $error("accepted transaction did not hold busy");

  a_result_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |=> !busy && !result_valid_o)
    else $error("sequencer did not return to idle after result");

  a_purge_ok : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && op_q == OP_PURGE) |-> ok_o)
    else $error("purge reported failure");

endmodule

`default_nettype wire

// ===== bench/deque_with_negative_purge_test.sv =====
`timescale 1ns / 1ps

module deque_with_negative_purge_test;
  import dq_pkg::*;

  // Opcodes outside the defined set; the block must answer them with ok low.
  localparam logic [2:0] OP_UNDEF_FIRST = 3'd5;
  localparam logic [2:0] OP_UNDEF_MID   = 3'd6;
  localparam logic [2:0] OP_UNDEF_LAST  = 3'd7;

  localparam logic signed [VALUE_BITS-1:0] VALUE_MAX = {1'b0, {(VALUE_BITS-1){1'b1}}};
  localparam logic signed [VALUE_BITS-1:0] VALUE_MIN = {1'b1, {(VALUE_BITS-1){1'b0}}};

  // Slowest transaction (full purge) plus margin, used for the final settle.
  localparam int SETTLE_CYCLES = 2 * DEPTH + 16;

  // What one result strobe reports about the deque.
  typedef struct {
    logic                         ok;
    logic [CNT_W-1:0]             count;
    logic                         empty;
    logic signed [VALUE_BITS-1:0] front;
    logic signed [VALUE_BITS-1:0] back;
  } deque_view_t;

  logic                         clk_i = 1'b0;
  logic                         rst_ni;
  logic                         start;
  logic                         busy;
  logic [2:0]                   opcode_i;
  logic signed [VALUE_BITS-1:0] value_i;
  logic                         result_valid_o;
  logic                         ok_o;
  logic [CNT_W-1:0]             entry_count_o;
  logic                         is_empty_o;
  logic signed [VALUE_BITS-1:0] front_value_o;
  logic signed [VALUE_BITS-1:0] back_value_o;

  // Shadow copy of the deque, updated at each accepted transaction.
  logic signed [VALUE_BITS-1:0] shadow_store [DEPTH];
  int                           shadow_head;
  int                           shadow_count;

  deque_view_t expected_views [$];
  int          fail_count;
  bit          gaps_enabled;

  deque_with_negative_purge dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .opcode_i       (opcode_i),
    .value_i        (value_i),
    .result_valid_o (result_valid_o),
    .ok_o           (ok_o),
    .entry_count_o  (entry_count_o),
    .is_empty_o     (is_empty_o),
    .front_value_o  (front_value_o),
    .back_value_o   (back_value_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Apply one operation to the shadow deque and queue the view the block
  // should report afterwards. Failed pushes/pops and undefined opcodes leave
  // the shadow untouched.
  function automatic void predict_deque_view(input logic [2:0] op,
                                             input logic signed [VALUE_BITS-1:0] val);
    deque_view_t                  view;
    int                           kept;
    logic signed [VALUE_BITS-1:0] entry;
    view.ok = 1'b0;
    case (op)
      OP_PUSH_FRONT: begin
        if (shadow_count < DEPTH) begin
          shadow_head = (shadow_head + DEPTH - 1) % DEPTH;
          shadow_store[shadow_head] = val;
          shadow_count++;
          view.ok = 1'b1;
        end
      end
      OP_PUSH_BACK: begin
        if (shadow_count < DEPTH) begin
          shadow_store[(shadow_head + shadow_count) % DEPTH] = val;
          shadow_count++;
          view.ok = 1'b1;
        end
      end
      OP_POP_FRONT: begin
        if (shadow_count > 0) begin
          shadow_head = (shadow_head + 1) % DEPTH;
          shadow_count--;
          view.ok = 1'b1;
        end
      end
      OP_POP_BACK: begin
        if (shadow_count > 0) begin
          shadow_count--;
          view.ok = 1'b1;
        end
      end
      OP_PURGE: begin
        // Pack the non-negative survivors toward the front; head stays put.
        kept = 0;
        for (int i = 0; i < shadow_count; i++) begin
          entry = shadow_store[(shadow_head + i) % DEPTH];
          if (!entry[VALUE_BITS-1]) begin
            shadow_store[(shadow_head + kept) % DEPTH] = entry;
            kept++;
          end
        end
        shadow_count = kept;
        view.ok = 1'b1;
      end
      default: begin
      end
    endcase
    view.count = CNT_W'(shadow_count);
    view.empty = (shadow_count == 0);
    if (shadow_count > 0) begin
      view.front = shadow_store[shadow_head];
      view.back  = shadow_store[(shadow_head + shadow_count - 1) % DEPTH];
    end else begin
      view.front = '0;
      view.back  = '0;
    end
    expected_views.push_back(view);
  endfunction

  function automatic bit field_matches(input string field,
                                       input logic [VALUE_BITS-1:0] want,
                                       input logic [VALUE_BITS-1:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch: expected %h, actual %h", $time, field, want, got);
      return 1'b0;
    end
    return 1'b1;
  endfunction

  // Compare every result strobe against the oldest pending view.
  always @(posedge clk_i) begin : check_results
    deque_view_t want;
    if (rst_ni === 1'b1 && result_valid_o !== 1'b0) begin
      if (expected_views.size() == 0) begin
        $display("%0t: result strobe with no transaction pending (valid=%b)",
                 $time, result_valid_o);
        fail_count++;
      end else begin
        want = expected_views.pop_front();
        if (!(field_matches("result_valid", 1'b1, result_valid_o)
              & field_matches("ok", want.ok, ok_o)
              & field_matches("entry_count", want.count, entry_count_o)
              & field_matches("is_empty", want.empty, is_empty_o)
              & field_matches("front_value", want.front, front_value_o)
              & field_matches("back_value", want.back, back_value_o))) begin
          fail_count++;
        end
      end
    end
  end

  // Mostly back-to-back, otherwise a random pause, now and then a longer
  // one.
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 90) return $urandom_range(1, 4);
    return $urandom_range(8, 45);
  endfunction

  // Bias toward extremes and small magnitudes of both signs so purges have
  // negatives to drop and survivors to keep.
  function automatic logic signed [VALUE_BITS-1:0] pick_value();
    int roll;
    roll = $urandom_range(0, 5);
    case (roll)
      0: begin
        case ($urandom_range(0, 3))
          0:       return VALUE_MAX;
          1:       return VALUE_MIN;
          2:       return '0;
          default: return '1;
        endcase
      end
      1:       return VALUE_BITS'($urandom_range(0, 100));
      2:       return -VALUE_BITS'($urandom_range(1, 100));
      default: return VALUE_BITS'($urandom());
    endcase
  endfunction

  // Drive one transaction from a falling edge, hold it until the block takes
  // it, then record the prediction. Leave start high when the next transaction
  // follows at once, so start is never dropped and raised in the same step.
  task automatic send_op(input logic [2:0] op, input logic signed [VALUE_BITS-1:0] val);
    int gap;
    start    <= 1'b1;
    opcode_i <= op;
    value_i  <= val;
    do @(posedge clk_i); while (busy !== 1'b0);
    predict_deque_view(op, val);
    @(negedge clk_i);
    gap = gaps_enabled ? pick_gap() : 0;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
  endtask

  // Hold off new transactions until every pending result has arrived.
  task automatic wait_for_drain();
    start <= 1'b0;
    do @(negedge clk_i); while (expected_views.size() != 0);
  endtask

  // Operations on the empty deque: pops fail, purge succeeds, junk opcode fails.
  task automatic test_empty_ops();
    send_op(OP_POP_FRONT, VALUE_MAX);
    send_op(OP_POP_BACK, VALUE_MIN);
    send_op(OP_PURGE, '1);
    send_op(OP_UNDEF_LAST, 32'sd5);
  endtask

  // Extreme values at both ends, a purge that drops some and keeps the order
  // of the rest, a purge with nothing to drop, then pop back down to empty.
  task automatic test_extremes();
    send_op(OP_PUSH_FRONT, VALUE_MAX);
    send_op(OP_PUSH_BACK, VALUE_MIN);
    send_op(OP_PUSH_FRONT, '1);
    send_op(OP_PUSH_BACK, '0);
    send_op(OP_PUSH_FRONT, 32'sd1);
    send_op(OP_UNDEF_FIRST, VALUE_MIN);
    send_op(OP_PURGE, '0);
    send_op(OP_PURGE, '0);
    send_op(OP_UNDEF_MID, VALUE_MAX);
    send_op(OP_POP_FRONT, '0);
    send_op(OP_POP_BACK, '0);
    send_op(OP_POP_BACK, '0);
    send_op(OP_POP_FRONT, '0);
  endtask

  // Fill past capacity from both ends so pushes to a full deque fail, then
  // purge a full store.
  task automatic test_fill_overflow();
    for (int i = 0; i < DEPTH + 3; i++) begin
      send_op($urandom_range(0, 1) ? OP_PUSH_FRONT : OP_PUSH_BACK, pick_value());
    end
    send_op(OP_PURGE, pick_value());
  endtask

  // Random traffic with the given mix in percent; the rest are undefined opcodes.
  task automatic test_random_mix(input int count, input int push_pct,
                                 input int pop_pct, input int purge_pct);
    int roll;
    for (int i = 0; i < count; i++) begin
      roll = $urandom_range(0, 99);
      if (roll < push_pct) begin
        send_op($urandom_range(0, 1) ? OP_PUSH_FRONT : OP_PUSH_BACK, pick_value());
      end else if (roll < push_pct + pop_pct) begin
        send_op($urandom_range(0, 1) ? OP_POP_FRONT : OP_POP_BACK, pick_value());
      end else if (roll < push_pct + pop_pct + purge_pct) begin
        send_op(OP_PURGE, pick_value());
      end else begin
        send_op(3'($urandom_range(OP_UNDEF_FIRST, OP_UNDEF_LAST)), pick_value());
      end
    end
  endtask

  initial begin
    rst_ni       = 1'b0;
    start        = 1'b0;
    opcode_i     = '0;
    value_i      = '0;
    fail_count   = 0;
    gaps_enabled = 1'b1;
    shadow_head  = 0;
    shadow_count = 0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_empty_ops();
    test_extremes();
    test_fill_overflow();
    wait_for_drain();

    // Balanced traffic keeps the level wandering around the middle.
    test_random_mix(350, 42, 40, 14);
    // Push-heavy drives the deque to full and into overflow attempts.
    test_random_mix(250, 75, 15, 7);
    wait_for_drain();
    // Pop-heavy drains it and hammers pops on empty.
    test_random_mix(200, 20, 70, 7);
    // Back-to-back transactions with no idle cycles at all.
    gaps_enabled = 1'b0;
    test_random_mix(200, 45, 35, 17);
    gaps_enabled = 1'b1;
    // Purge-heavy with enough pushes to keep negatives stored.
    test_random_mix(220, 55, 20, 22);

    wait_for_drain();
    repeat (SETTLE_CYCLES) @(negedge clk_i);
    if (fail_count == 0 && expected_views.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // Hard stop well beyond the slowest legal run.
  initial begin
    #1_000_000;
    $display("Verification failed");
    $finish;
  end

endmodule
